// ===== rtl/assert_macros.svh =====
// assertion helpers for the lattice update block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/imlu_pkg.sv =====
package imlu_pkg;

  // default lattice side and acceptance precision
  localparam int SIDE_DEF      = 256;
  localparam int PROB_BITS_DEF = 16;

  // fixed field widths
  localparam int CFG_W    = 16;
  localparam int ENERGY_W = 20;
  localparam int E_MAX    = 524287;
  localparam int E_MIN    = -524288;

  // operation codes carried on in_tuser
  typedef enum logic [1:0] {
    FN_WRITE  = 2'd0,
    FN_TRIAL  = 2'd1,
    FN_READ   = 2'd2,
    FN_ENERGY = 2'd3
  } func_t;

  // configuration register indexes
  localparam logic REG_THRESH_4 = 1'b0;
  localparam logic REG_THRESH_8 = 1'b1;

  // control of the energy accumulator, aligned with the memory read data
  typedef struct packed {
    logic clr;
    logic vld;
    logic first;
    logic last;
  } scan_ctl_t;

endpackage

// ===== rtl/imlu_grid_mem.sv =====
module imlu_grid_mem #(
  parameter int SIDE  = imlu_pkg::SIDE_DEF,
  parameter int IDX_W = $clog2(SIDE)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] wr_row,
  input  logic [IDX_W-1:0] wr_col,
  input  logic             wr_bit,
  input  logic             re,
  input  logic [IDX_W-1:0] rd_a_row,
  input  logic [IDX_W-1:0] rd_a_col,
  input  logic [IDX_W-1:0] rd_b_row,
  input  logic [IDX_W-1:0] rd_b_col,
  output logic             rd_a_bit,
  output logic             rd_b_bit
);

  // one bit per site, 1 is a +1 spin
  logic grid_mem [SIDE][SIDE];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      grid_mem[wr_row][wr_col] <= wr_bit;
    end
  end

  // two registered read ports, data held while not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rd_a_bit <= grid_mem[rd_a_row][rd_a_col];
      rd_b_bit <= grid_mem[rd_b_row][rd_b_col];
    end
  end

endmodule

// ===== rtl/imlu_energy_acc.sv =====
module imlu_energy_acc #(
  parameter int SIDE = imlu_pkg::SIDE_DEF
) (
  input  logic                                  clk,
  input  imlu_pkg::scan_ctl_t                   ctl,
  input  logic                                  cur_bit,
  input  logic                                  down_bit,
  output logic signed [imlu_pkg::ENERGY_W-1:0]  energy
);

  // bond count range is twice the site count in magnitude
  localparam int ACC_W = $clog2(2 * SIDE * SIDE + 1) + 1;
  localparam int EXT_W = (ACC_W + 1 > imlu_pkg::ENERGY_W + 1) ? ACC_W + 1
                                                               : imlu_pkg::ENERGY_W + 1;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic                    prev_bit_r;
  logic                    first_bit_r;
  logic signed [2:0]       delta;
  logic signed [EXT_W-1:0] e_ext;

  function automatic logic signed [2:0] bond(input logic a, input logic b);
    return (a == b) ? 3'sd1 : -3'sd1;
  endfunction

  // each site adds its left bond, its down bond and at row end the wrap bond
  always_comb begin
    delta = bond(cur_bit, down_bit);
    if (!ctl.first) begin
      delta = delta + bond(prev_bit_r, cur_bit);
    end
    if (ctl.last) begin
      delta = delta + bond(cur_bit, first_bit_r);
    end
    acc_nxt = acc_r + ACC_W'(delta);
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.vld) begin
      acc_r <= acc_nxt;
    end
    if (ctl.vld) begin
      prev_bit_r <= cur_bit;
      if (ctl.first) begin
        first_bit_r <= cur_bit;
      end
    end
  end

  // energy is twice the bond sum, saturated
  always_comb begin
    e_ext = EXT_W'($signed({acc_r, 1'b0}));
    if (e_ext > $signed(EXT_W'(imlu_pkg::E_MAX))) begin
      energy = imlu_pkg::ENERGY_W'(imlu_pkg::E_MAX);
    end else if (e_ext < $signed(EXT_W'(imlu_pkg::E_MIN))) begin
      energy = imlu_pkg::ENERGY_W'(imlu_pkg::E_MIN);
    end else begin
      energy = e_ext[imlu_pkg::ENERGY_W-1:0];
    end
  end

endmodule

// ===== rtl/ising_metropolis_lattice_update.sv =====
// Ising lattice with Metropolis single-site updates on a SIDE x SIDE torus held in a
// one-bit-per-site memory with two registered read ports. Each input transaction carries
// an operation on in_tuser: write spin, read spin, a Metropolis trial (five spin reads over
// the two read ports, then the decision and write-back) or a total energy readout, one site
// per cycle through the read ports. One item is in work at a time; the next is taken while
// a finished result still waits in the output register. The user must write thresholds on
// the cfg port only while the block is idle; the block itself does not enforce it. Spins
// must be written before they are read.
`include "assert_macros.svh"

module ising_metropolis_lattice_update #(
  parameter int SIDE      = imlu_pkg::SIDE_DEF,
  parameter int PROB_BITS = imlu_pkg::PROB_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input transactions
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [39:0]               in_tdata,  // row, col, spin_value, random_u, zero pad
  input  logic [1:0]                in_tuser,  // func
  // result transactions
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata, // spin_out, flipped, total_energy, zero pad
  // configuration writes
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [imlu_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(SIDE);
  localparam int TH_W  = (PROB_BITS < imlu_pkg::CFG_W) ? PROB_BITS : imlu_pkg::CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIDE - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RDB   = 6'b000010,
    ST_RDC   = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  imlu_pkg::func_t        func_r;
  logic [IDX_W-1:0]       row_r, col_r;
  logic                   sv_r;
  logic [TH_W-1:0]        u_r;
  logic [TH_W-1:0]        th4_r, th8_r;
  logic                   c_r, up_r, dn_r, lf_r;
  logic [IDX_W-1:0]       scan_row_r, scan_col_r;
  logic                   scan_vld_r, scan_first_r, scan_last_r, scan_clr_r;
  logic                   out_tvalid_r;
  logic                   out_spin_r, out_flip_r;
  logic signed [imlu_pkg::ENERGY_W-1:0] out_energy_r;

  logic [IDX_W-1:0]       mod_tbl [256];
  logic                   in_acc;
  imlu_pkg::func_t        in_func;
  logic [IDX_W-1:0]       in_row_m, in_col_m, in_row_up;
  logic [IDX_W-1:0]       row_dn, col_lf, col_rt, scan_dn;
  logic                   mem_we, mem_wbit, mem_re;
  logic [IDX_W-1:0]       rd_a_row, rd_a_col, rd_b_row, rd_b_col;
  logic                   rd_a_bit, rd_b_bit;
  logic                   out_free, fin_go, scan_end;
  logic [2:0]             n_agree;
  logic                   flip, res_spin, res_flip;
  logic signed [imlu_pkg::ENERGY_W-1:0] energy;
  imlu_pkg::scan_ctl_t    scan_ctl;

  // 8-bit address fields reduced modulo the lattice side
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tbl[g] = IDX_W'(g % SIDE);
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_func   = imlu_pkg::func_t'(in_tuser);
  assign in_row_m  = mod_tbl[in_tdata[7:0]];
  assign in_col_m  = mod_tbl[in_tdata[15:8]];
  assign in_row_up = (in_row_m == '0) ? LAST_IDX : in_row_m - 1'b1;

  // neighbor indexes with wrap-around
  assign row_dn  = (row_r == LAST_IDX) ? '0 : row_r + 1'b1;
  assign col_lf  = (col_r == '0) ? LAST_IDX : col_r - 1'b1;
  assign col_rt  = (col_r == LAST_IDX) ? '0 : col_r + 1'b1;
  assign scan_dn = (scan_row_r == LAST_IDX) ? '0 : scan_row_r + 1'b1;
  assign scan_end = (scan_row_r == LAST_IDX) && (scan_col_r == LAST_IDX);

  assign out_free = !out_tvalid_r || out_tready;
  assign fin_go   = (state_r == ST_FIN) && out_free;

  // read port addressing: center and up at accept, down and left, then right
  always_comb begin
    mem_re   = 1'b0;
    rd_a_row = row_r;
    rd_a_col = col_r;
    rd_b_row = row_r;
    rd_b_col = col_r;
    unique case (state_r)
      ST_IDLE: begin
        mem_re   = in_acc && (in_func == imlu_pkg::FN_TRIAL || in_func == imlu_pkg::FN_READ);
        rd_a_row = in_row_m;
        rd_a_col = in_col_m;
        rd_b_row = in_row_up;
        rd_b_col = in_col_m;
      end
      ST_RDB: begin
        mem_re   = 1'b1;
        rd_a_row = row_dn;
        rd_b_col = col_lf;
      end
      ST_RDC: begin
        mem_re   = 1'b1;
        rd_a_col = col_rt;
      end
      ST_SCAN: begin
        mem_re   = 1'b1;
        rd_a_row = scan_row_r;
        rd_a_col = scan_col_r;
        rd_b_row = scan_dn;
        rd_b_col = scan_col_r;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Metropolis decision from the count of neighbors agreeing with the center
  always_comb begin
    n_agree = {2'b00, up_r ~^ c_r} + {2'b00, dn_r ~^ c_r} + {2'b00, lf_r ~^ c_r}
            + {2'b00, rd_a_bit ~^ c_r};
    if (n_agree >= 3'd2) begin
      flip = 1'b1;
    end else if (n_agree == 3'd1) begin
      flip = th4_r > u_r;
    end else begin
      flip = th8_r > u_r;
    end
  end

  // result and write-back per operation
  always_comb begin
    res_spin = 1'b0;
    res_flip = 1'b0;
    mem_wbit = sv_r;
    mem_we   = 1'b0;
    unique case (func_r)
      imlu_pkg::FN_WRITE: begin
        res_spin = sv_r;
        mem_we   = fin_go;
      end
      imlu_pkg::FN_TRIAL: begin
        res_spin = c_r ^ flip;
        res_flip = flip;
        mem_wbit = ~c_r;
        mem_we   = fin_go && flip;
      end
      imlu_pkg::FN_READ: begin
        res_spin = rd_a_bit;
      end
      imlu_pkg::FN_ENERGY: begin
        res_spin = 1'b0;
      end
      default: begin
        res_spin = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_func)
            imlu_pkg::FN_TRIAL:  state_nxt = ST_RDB;
            imlu_pkg::FN_ENERGY: state_nxt = ST_SCAN;
            imlu_pkg::FN_WRITE:  state_nxt = ST_FIN;
            imlu_pkg::FN_READ:   state_nxt = ST_FIN;
            default:             state_nxt = ST_FIN;
          endcase
        end
      end
      ST_RDB:   state_nxt = ST_RDC;
      ST_RDC:   state_nxt = ST_FIN;
      ST_SCAN:  state_nxt = scan_end ? ST_DRAIN : ST_SCAN;
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN:   state_nxt = out_free ? ST_IDLE : ST_FIN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      scan_vld_r   <= 1'b0;
      scan_clr_r   <= 1'b0;
      th4_r        <= '0;
      th8_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_vld_r <= (state_r == ST_SCAN);
      scan_clr_r <= in_acc && (in_func == imlu_pkg::FN_ENERGY);
      if (fin_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          imlu_pkg::REG_THRESH_4: th4_r <= cfg_wdata[TH_W-1:0];
          imlu_pkg::REG_THRESH_8: th8_r <= cfg_wdata[TH_W-1:0];
          default:                th4_r <= th4_r;
        endcase
      end
    end
  end

  // item fields, neighbor captures, scan counters and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r     <= in_func;
      row_r      <= in_row_m;
      col_r      <= in_col_m;
      sv_r       <= in_tdata[16];
      u_r        <= in_tdata[17 +: TH_W];
      scan_row_r <= '0;
      scan_col_r <= '0;
    end else if (state_r == ST_SCAN) begin
      scan_col_r <= (scan_col_r == LAST_IDX) ? '0 : scan_col_r + 1'b1;
      if (scan_col_r == LAST_IDX) begin
        scan_row_r <= scan_dn;
      end
    end
    if (state_r == ST_RDB) begin
      c_r  <= rd_a_bit;
      up_r <= rd_b_bit;
    end
    if (state_r == ST_RDC) begin
      dn_r <= rd_a_bit;
      lf_r <= rd_b_bit;
    end
    scan_first_r <= (scan_col_r == '0);
    scan_last_r  <= (scan_col_r == LAST_IDX);
    if (fin_go) begin
      out_spin_r   <= res_spin;
      out_flip_r   <= res_flip;
      out_energy_r <= (func_r == imlu_pkg::FN_ENERGY) ? energy : '0;
    end
  end

  assign scan_ctl = '{clr: scan_clr_r, vld: scan_vld_r, first: scan_first_r,
                      last: scan_last_r};

  imlu_grid_mem #(
    .SIDE  (SIDE),
    .IDX_W (IDX_W)
  ) u_grid_mem (
    .clk      (clk),
    .we       (mem_we),
    .wr_row   (row_r),
    .wr_col   (col_r),
    .wr_bit   (mem_wbit),
    .re       (mem_re),
    .rd_a_row (rd_a_row),
    .rd_a_col (rd_a_col),
    .rd_b_row (rd_b_row),
    .rd_b_col (rd_b_col),
    .rd_a_bit (rd_a_bit),
    .rd_b_bit (rd_b_bit)
  );

  imlu_energy_acc #(
    .SIDE (SIDE)
  ) u_energy_acc (
    .clk      (clk),
    .ctl      (scan_ctl),
    .cur_bit  (rd_a_bit),
    .down_bit (rd_b_bit),
    .energy   (energy)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_energy_r, out_flip_r, out_spin_r};

  // checks
  `ASSERT_ALWAYS(a_no_rw_overlap, !(mem_we && mem_re), "grid write overlaps a grid read")
  `ASSERT_NEXT(a_fin_loads_out, fin_go, out_tvalid_r, "finished item did not reach the output")
  `ASSERT_ALWAYS(a_scan_vld_phase, !scan_vld_r || state_r == ST_SCAN || state_r == ST_DRAIN, "scan data outside the energy walk")

endmodule
